[sv/isv_pkg.sv]
// isv_pkg: shared constants for the info string validator
// verdict codes, the special byte values and the verdict type; no dependencies
`timescale 1ns / 1ps

package isv_pkg;

    // verdict codes carried on the status field
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_MISSING_KEY   = 3'd1;
    localparam logic [2:0] ST_MISSING_VALUE = 3'd2;
    localparam logic [2:0] ST_ILLEGAL       = 3'd3;
    localparam logic [2:0] ST_LONG_KEY      = 3'd4;
    localparam logic [2:0] ST_LONG_VALUE    = 3'd5;
    localparam logic [2:0] ST_LONG_STRING   = 3'd6;

    // byte values with special meaning
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] status;
    } t_verdict;

endpackage

[sv/info_string_validator_core.sv]
// info_string_validator_core: top level of the info string validator
// uses isv_pkg for verdict codes, byte constants and the verdict type
`timescale 1ns / 1ps

// Usage
//   input channel: one string byte per request on i_char_code, qualified by
//   i_in_valid and held off by o_in_stall. a zero byte ends the string.
//   output channel: one verdict per terminated string on o_valid_res and
//   o_status, qualified by o_out_valid and held off by i_out_stall.
//   non-zero bytes only update the parse state and give no verdict.
// Throughput: one byte per cycle while o_in_stall is low; the parse state
//   is a single register set updated by one level of compare and increment
//   logic per byte. The verdict of a taken terminator is registered into the
//   output register, or into the skid register while the output is stalled.
// Stall: verdicts go into a two-entry output queue (output register plus a
//   skid register). while the receiver stalls, one further verdict can be
//   absorbed; o_in_stall rises only once both entries are full.
// Reset: i_rst_n is synchronous and active low. it returns the parser to the
//   start of a string with no error and empties the output queue.
module info_string_validator_core #(
    parameter int STRING_LIMIT = 512,
    parameter int KEY_LIMIT    = 64,
    parameter int VALUE_LIMIT  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    // verdict channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_valid_res,
    output logic [2:0] o_status
);

    // counter widths: a field never holds more than its limit minus one, the
    // incremented value at most the limit itself
    localparam int FIELD_MAX = (KEY_LIMIT > VALUE_LIMIT) ? KEY_LIMIT : VALUE_LIMIT;
    localparam int FW        = $clog2(FIELD_MAX + 1);
    localparam int TW        = $clog2(STRING_LIMIT + 1);

    localparam logic [FW-1:0] KEY_LIM_W   = FW'(KEY_LIMIT);
    localparam logic [FW-1:0] VALUE_LIM_W = FW'(VALUE_LIMIT);
    localparam logic [TW-1:0] STR_LIM_W   = TW'(STRING_LIMIT);

    typedef enum logic [2:0] {
        PH_START,        // before anything, a leading backslash allowed
        PH_KEY_FIRST,    // key begins
        PH_KEY,          // inside key
        PH_VALUE_FIRST,  // value begins
        PH_VALUE         // inside value
    } t_phase;

    // parse state
    t_phase          r_phase,     n_phase;
    logic [FW-1:0]   r_field_len, n_field_len;
    logic [TW-1:0]   r_total_len, n_total_len;
    logic [2:0]      r_first_err, n_first_err;

    // output queue
    logic               r_out_valid,  n_out_valid;
    isv_pkg::t_verdict  r_out,        n_out;
    logic               r_skid_valid, n_skid_valid;
    isv_pkg::t_verdict  r_skid,       n_skid;

    // per-byte decode
    logic              in_take;
    logic              is_term;
    logic              is_bslash;
    logic              is_illegal;
    logic              key_side;
    logic [FW-1:0]     field_inc;
    logic [TW-1:0]     total_inc;
    logic [FW-1:0]     field_lim;
    logic [2:0]        long_code;
    logic [2:0]        verdict_code;
    isv_pkg::t_verdict new_verdict;
    logic              out_take;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    assign is_term    = (i_char_code == isv_pkg::CH_NUL);
    assign is_bslash  = (i_char_code == isv_pkg::CH_BACKSLASH);
    assign is_illegal = (i_char_code < isv_pkg::CH_PRINT_LO)
                     || (i_char_code > isv_pkg::CH_PRINT_HI)
                     || (i_char_code == isv_pkg::CH_DQUOTE)
                     || (i_char_code == isv_pkg::CH_SEMICOLON);
    assign key_side   = (r_phase == PH_START) || (r_phase == PH_KEY_FIRST)
                     || (r_phase == PH_KEY);
    assign field_inc  = r_field_len + FW'(1);
    assign total_inc  = r_total_len + TW'(1);
    assign field_lim  = key_side ? KEY_LIM_W : VALUE_LIM_W;
    assign long_code  = key_side ? isv_pkg::ST_LONG_KEY : isv_pkg::ST_LONG_VALUE;

    // verdict at the terminator: first error wins, else judged by phase
    always_comb begin
        if (r_first_err != isv_pkg::ST_OK) begin
            verdict_code = r_first_err;
        end else begin
            unique case (r_phase)
                PH_VALUE:                verdict_code = isv_pkg::ST_OK;
                PH_KEY, PH_VALUE_FIRST:  verdict_code = isv_pkg::ST_MISSING_VALUE;
                default:                 verdict_code = isv_pkg::ST_MISSING_KEY;
            endcase
        end
        new_verdict.valid_res = (verdict_code == isv_pkg::ST_OK);
        new_verdict.status    = verdict_code;
    end

    // parse state update
    always_comb begin
        n_phase     = r_phase;
        n_field_len = r_field_len;
        n_total_len = r_total_len;
        n_first_err = r_first_err;
        if (in_take) begin
            if (is_term) begin
                // restart for the next string
                n_phase     = PH_START;
                n_field_len = '0;
                n_total_len = '0;
                n_first_err = isv_pkg::ST_OK;
            end else if (r_first_err == isv_pkg::ST_OK) begin
                if (is_bslash) begin
                    // separator counts toward the string length only
                    if (total_inc >= STR_LIM_W) begin
                        n_first_err = isv_pkg::ST_LONG_STRING;
                    end else begin
                        n_total_len = total_inc;
                        n_field_len = '0;
                        if (r_phase == PH_START) begin
                            n_phase = PH_KEY_FIRST;
                        end else if (key_side) begin
                            n_phase = PH_VALUE_FIRST;
                        end else begin
                            n_phase = PH_KEY_FIRST;
                        end
                    end
                end else if (is_illegal) begin
                    n_first_err = isv_pkg::ST_ILLEGAL;
                end else if (field_inc >= field_lim) begin
                    n_first_err = long_code;
                end else if (total_inc >= STR_LIM_W) begin
                    n_first_err = isv_pkg::ST_LONG_STRING;
                end else begin
                    n_field_len = field_inc;
                    n_total_len = total_inc;
                    n_phase     = key_side ? PH_KEY : PH_VALUE;
                end
            end
        end
    end

    // output queue: skid entry refills the output register first
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = in_take && is_term;
                n_skid       = new_verdict;
            end else begin
                n_out_valid = in_take && is_term;
                n_out       = new_verdict;
            end
        end else if (in_take && is_term) begin
            n_skid_valid = 1'b1;
            n_skid       = new_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_field_len  <= '0;
            r_total_len  <= '0;
            r_first_err  <= isv_pkg::ST_OK;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_field_len  <= n_field_len;
            r_total_len  <= n_total_len;
            r_first_err  <= n_first_err;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // hold off new bytes only while both queue entries are full
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_out.valid_res;
    assign o_status    = r_out.status;

endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for info_string_validator_core
// depends on isv_pkg (verdict codes, byte constants, t_verdict) and the core itself
`timescale 1ns / 1ps

module tb_top;

    localparam int STRING_LIMIT = 512;
    localparam int KEY_LIMIT    = 64;
    localparam int VALUE_LIMIT  = 64;
    localparam int NUM_BYTES    = 1700;  // no new string starts once this many byte requests are sent
    localparam int IDLE_LIMIT   = 2000;  // cycles with no request moving
    localparam int DRAIN_CYCLES = 8;

    // parse position inside the string, mirrored in the predictor
    typedef enum logic [2:0] {
        PS_START,
        PS_KEY_FIRST,
        PS_KEY,
        PS_VALUE_FIRST,
        PS_VALUE
    } t_parse_pos;

    // one directed byte; typed rows carry a verdict read off by hand
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        logic       want_ok;
        logic [2:0] want_status;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_valid_res;
    logic [2:0] o_status;

    info_string_validator_core #(
        .STRING_LIMIT(STRING_LIMIT),
        .KEY_LIMIT   (KEY_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_char_code(i_char_code),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_valid_res(o_valid_res),
        .o_status   (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_parse_pos parse_pos   = PS_START;
    int         field_len   = 0;
    int         total_len   = 0;
    logic [2:0] first_err   = isv_pkg::ST_OK;

    isv_pkg::t_verdict pending_verdicts[$];
    logic [7:0]        str_q[$];

    int errors       = 0;
    int bytes_sent   = 0;
    int strings_sent = 0;
    int verdicts_chk = 0;
    int long_strings = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int rcv_mode     = 0;
    int rcv_left     = 0;
    int status_seen[8];

    // directed bytes: the ok, missing key, missing value and illegal verdicts, the
    // printable extremes, illegal bytes at both ends of the code range, and bytes ignored after an error
    t_row dir_rows [24] = '{
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_MISSING_KEY},   // empty string
        '{isv_pkg::CH_BACKSLASH, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_MISSING_KEY},   // lone separator
        '{"k",                   1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_MISSING_VALUE}, // inside key
        '{"k",                   1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_BACKSLASH, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_MISSING_VALUE}, // after key sep
        '{"k",                   1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_BACKSLASH, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{"v",                   1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_BACKSLASH, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_MISSING_KEY},   // after value sep
        '{isv_pkg::CH_PRINT_LO,  1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_BACKSLASH, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_PRINT_HI,  1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b1, isv_pkg::ST_OK},            // extremes pass
        '{8'h1F,                 1'b0, 1'b0, isv_pkg::ST_OK},
        '{"a",                   1'b0, 1'b0, isv_pkg::ST_OK},            // ignored
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_ILLEGAL},
        '{isv_pkg::CH_SEMICOLON, 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_ILLEGAL},
        '{8'hFF,                 1'b0, 1'b0, isv_pkg::ST_OK},
        '{isv_pkg::CH_NUL,       1'b1, 1'b0, isv_pkg::ST_ILLEGAL}
    };

    // advance the predicted parser by one byte; returns 1 when a verdict is due
    function automatic bit parse_byte(input logic [7:0] c, output isv_pkg::t_verdict v);
        logic [2:0] code;
        bit         in_key;
        v = '0;
        if (c == isv_pkg::CH_NUL) begin
            code = first_err;
            if (code == isv_pkg::ST_OK) begin
                if (parse_pos == PS_VALUE)
                    code = isv_pkg::ST_OK;
                else if (parse_pos == PS_KEY || parse_pos == PS_VALUE_FIRST)
                    code = isv_pkg::ST_MISSING_VALUE;
                else
                    code = isv_pkg::ST_MISSING_KEY;
            end
            v.valid_res = (code == isv_pkg::ST_OK);
            v.status    = code;
            parse_pos   = PS_START;
            field_len   = 0;
            total_len   = 0;
            first_err   = isv_pkg::ST_OK;
            return 1'b1;
        end
        if (first_err != isv_pkg::ST_OK)
            return 1'b0;
        in_key = (parse_pos == PS_START || parse_pos == PS_KEY_FIRST
                  || parse_pos == PS_KEY);
        if (c == isv_pkg::CH_BACKSLASH) begin
            // separators count toward the string length only
            total_len++;
            if (total_len >= STRING_LIMIT) begin
                first_err = isv_pkg::ST_LONG_STRING;
            end else begin
                field_len = 0;
                if (parse_pos == PS_START)
                    parse_pos = PS_KEY_FIRST;
                else if (in_key)
                    parse_pos = PS_VALUE_FIRST;
                else
                    parse_pos = PS_KEY_FIRST;
            end
        end else if (c < isv_pkg::CH_PRINT_LO || c > isv_pkg::CH_PRINT_HI
                     || c == isv_pkg::CH_DQUOTE || c == isv_pkg::CH_SEMICOLON) begin
            first_err = isv_pkg::ST_ILLEGAL;
        end else begin
            // illegal char, then field length, then string length
            field_len++;
            if (field_len >= (in_key ? KEY_LIMIT : VALUE_LIMIT)) begin
                first_err = in_key ? isv_pkg::ST_LONG_KEY : isv_pkg::ST_LONG_VALUE;
            end else begin
                total_len++;
                if (total_len >= STRING_LIMIT)
                    first_err = isv_pkg::ST_LONG_STRING;
                else
                    parse_pos = in_key ? PS_KEY : PS_VALUE;
            end
        end
        return 1'b0;
    endfunction

    // printable byte that is legal inside a key or value
    function automatic logic [7:0] rand_print();
        logic [7:0] c;
        c = 8'($urandom_range(isv_pkg::CH_PRINT_LO, isv_pkg::CH_PRINT_HI));
        while (c == isv_pkg::CH_DQUOTE || c == isv_pkg::CH_SEMICOLON
               || c == isv_pkg::CH_BACKSLASH)
            c = 8'($urandom_range(isv_pkg::CH_PRINT_LO, isv_pkg::CH_PRINT_HI));
        return c;
    endfunction

    function automatic void add_pair(input bit sep, input int klen, input int vlen);
        if (sep)
            str_q.push_back(isv_pkg::CH_BACKSLASH);
        repeat (klen) str_q.push_back(rand_print());
        str_q.push_back(isv_pkg::CH_BACKSLASH);
        repeat (vlen) str_q.push_back(rand_print());
    endfunction

    // one random string into str_q: mostly well formed, some near the limits,
    // some damaged, some plain noise
    function automatic void build_string();
        int pick;
        int n;
        int idx;
        int target;
        bit lead;
        str_q.delete();
        pick = $urandom_range(0, 99);
        lead = 1'($urandom_range(0, 1));
        if (pick < 2 && long_strings < 2) begin
            // many pairs that run the total length around its limit
            long_strings++;
            target = $urandom_range(STRING_LIMIT - 4, STRING_LIMIT + 4);
            n = 0;
            while (str_q.size() < target) begin
                add_pair(lead || n > 0, $urandom_range(0, 40), $urandom_range(1, 60));
                n++;
            end
        end else if (pick < 12) begin
            // one field straddling its length limit
            if ($urandom_range(0, 1) == 1)
                add_pair(lead, $urandom_range(KEY_LIMIT - 2, KEY_LIMIT + 1),
                         $urandom_range(1, 4));
            else
                add_pair(lead, $urandom_range(0, 4),
                         $urandom_range(VALUE_LIMIT - 2, VALUE_LIMIT + 1));
        end else if (pick >= 88) begin
            n = $urandom_range(1, 16);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    str_q.push_back(isv_pkg::CH_BACKSLASH);
                else
                    str_q.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            // short well-formed pairs, empty keys and inner values allowed; some then damaged
            n = $urandom_range(1, 4);
            for (idx = 0; idx < n; idx++)
                add_pair(lead || idx > 0, $urandom_range(0, 6),
                         (idx == n - 1) ? $urandom_range(1, 6) : $urandom_range(0, 6));
            if (pick >= 68) begin
                case ($urandom_range(0, 2))
                    0: begin
                        idx = $urandom_range(0, str_q.size() - 1);
                        str_q[idx] = 8'($urandom_range(1, 255));
                    end
                    1: begin
                        n = $urandom_range(0, str_q.size() - 1);
                        while (str_q.size() > n)
                            void'(str_q.pop_back());
                    end
                    default: str_q.push_back(isv_pkg::CH_BACKSLASH);
                endcase
            end
        end
        str_q.push_back(isv_pkg::CH_NUL);
    endfunction

    // drive one byte request, wait for it to be taken, then predict it;
    // the sender works in bursts separated by short gaps
    task automatic send_byte(input logic [7:0] c, input bit typed,
                             input isv_pkg::t_verdict want);
        isv_pkg::t_verdict got;
        bit                has_res;
        int                gap;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_in_stall);
        has_res = parse_byte(c, got);
        if (has_res) begin
            pending_verdicts.push_back(typed ? want : got);
            strings_sent++;
        end
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver stall pattern: free running, light random, or heavy stalling
    // in stretches, so the output queue fills and the input side stalls too
    always @(posedge i_clk) begin
        if (rcv_left == 0) begin
            rcv_mode = $urandom_range(0, 2);
            rcv_left = $urandom_range(20, 150);
        end else begin
            rcv_left--;
        end
        case (rcv_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // verdict checker and watchdog; values read here are those at the edge
    always @(posedge i_clk) begin
        isv_pkg::t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict with none expected: valid_res %0d status %0d",
                       o_valid_res, o_status);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_chk++;
                status_seen[want.status]++;
                if (o_valid_res !== want.valid_res) begin
                    $error("valid_res mismatch: expected %0d, actual %0d",
                           want.valid_res, o_valid_res);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_status);
                    errors++;
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        isv_pkg::t_verdict want;
        int                row;
        int                pos;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (row = 0; row < 24; row++) begin
            want.valid_res = dir_rows[row].want_ok;
            want.status    = dir_rows[row].want_status;
            send_byte(dir_rows[row].ch, dir_rows[row].typed, want);
        end

        // random part, checked by the predictor only
        want = '0;
        while (bytes_sent < NUM_BYTES) begin
            build_string();
            for (pos = 0; pos < str_q.size(); pos++)
                send_byte(str_q[pos], 1'b0, want);
        end
        i_in_valid <= 1'b0;

        // drain the verdicts, then watch a few more cycles for strays
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d bytes in %0d strings, %0d verdicts checked",
                 bytes_sent, strings_sent, verdicts_chk);
        $display("verdicts ok/mkey/mval/illegal/lkey/lval/lstr: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[isv_pkg::ST_OK], status_seen[isv_pkg::ST_MISSING_KEY],
                 status_seen[isv_pkg::ST_MISSING_VALUE], status_seen[isv_pkg::ST_ILLEGAL],
                 status_seen[isv_pkg::ST_LONG_KEY], status_seen[isv_pkg::ST_LONG_VALUE],
                 status_seen[isv_pkg::ST_LONG_STRING]);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
sv/isv_pkg.sv
sv/info_string_validator_core.sv
dv/tb_top.sv
